// File: rtl/qeae_pkg.sv
// Shared types and constants for the quaternion equal-area encoder.
package qeae_pkg;

  localparam int SMP_W  = 16;  // sample width, Q1.15
  localparam int FRAC_W = 30;  // fraction bits of internal Q2.30 values
  localparam int VAL_W  = 31;  // Q2.30 values up to 2^30 plus guard
  localparam int EPS_W  = 8;
  localparam int RAD_W  = 61;  // radicand and dividend width
  localparam int ROOT_W = 31;
  localparam int QUO_W  = 32;
  localparam int XY_W   = 35;  // CORDIC vector width, signed
  localparam int ACC_W  = 33;  // CORDIC angle accumulator, signed
  localparam int SF_W   = 33;  // signed scale factor
  localparam int PROD_W = SF_W + SMP_W;

  localparam logic [VAL_W-1:0] ONE_Q30 = VAL_W'(1) << FRAC_W;
  localparam logic [QUO_W-1:0] S_MAX   = QUO_W'(1) << 31;
  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

  // atan(2^-i) with a quarter turn equal to 2^30
  localparam logic [VAL_W-1:0] ATAN_TABLE [32] = '{
    31'd536870912, 31'd316933406, 31'd167458907, 31'd85004756,
    31'd42667331,  31'd21354465,  31'd10679838,  31'd5340245,
    31'd2670163,   31'd1335087,   31'd667544,    31'd333772,
    31'd166886,    31'd83443,     31'd41722,     31'd20861,
    31'd10430,     31'd5215,      31'd2608,      31'd1304,
    31'd652,       31'd326,       31'd163,       31'd81,
    31'd41,        31'd20,        31'd10,        31'd5,
    31'd3,         31'd1,         31'd1,         31'd0
  };

  typedef struct packed {
    logic signed [SMP_W-1:0] w_part;
    logic signed [SMP_W-1:0] x_part;
    logic signed [SMP_W-1:0] y_part;
    logic signed [SMP_W-1:0] z_part;
  } quat_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] vec_x;
    logic signed [SMP_W-1:0] vec_y;
    logic signed [SMP_W-1:0] vec_z;
  } vec_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] x;
    logic signed [SMP_W-1:0] y;
    logic signed [SMP_W-1:0] z;
  } smp_t;

  typedef struct packed {
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] w30;
    logic             wneg;
    logic             wzero;
    logic             dzero;
    smp_t             smp;
  } sq_side_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic [VAL_W-1:0]  w30;
    logic              wneg;
    logic              wzero;
    logic              dzero;
    smp_t              smp;
  } kd_side_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic              wneg;
    logic              dzero;
    smp_t              smp;
  } co_side_t;

  typedef struct packed {
    logic wneg;
    logic dzero;
    smp_t smp;
  } sd_side_t;

endpackage

// File: rtl/qeae_front.sv
// Input stage: |w|, a = 1 - w*w and the guarded radicand d.
module qeae_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  qeae_pkg::quat_t             quat,
  input  logic [qeae_pkg::EPS_W-1:0]  eps,
  output logic                        out_valid,
  output logic [qeae_pkg::VAL_W-1:0]  d,
  output qeae_pkg::sq_side_t          side
);

  logic [qeae_pkg::SMP_W-1:0]     wm;
  logic [2*qeae_pkg::SMP_W-1:0]   sq;
  logic [qeae_pkg::VAL_W-1:0]     a_c;
  logic [qeae_pkg::VAL_W-1:0]     d_c;
  qeae_pkg::sq_side_t             side_next;

  always_comb begin
    wm  = quat.w_part[qeae_pkg::SMP_W-1] ? qeae_pkg::SMP_W'(-quat.w_part)
                                         : qeae_pkg::SMP_W'(quat.w_part);
    sq  = (2*qeae_pkg::SMP_W)'(wm) * (2*qeae_pkg::SMP_W)'(wm);
    // w*w in Q2.30 is exactly wm*wm (wm has 15 frac bits)
    a_c = qeae_pkg::VAL_W'((2*qeae_pkg::SMP_W)'(qeae_pkg::ONE_Q30) - sq);
    d_c = a_c + qeae_pkg::VAL_W'(eps);
    side_next.a     = a_c;
    side_next.w30   = qeae_pkg::VAL_W'(wm) << (qeae_pkg::FRAC_W - (qeae_pkg::SMP_W - 1));
    side_next.wneg  = quat.w_part[qeae_pkg::SMP_W-1];
    side_next.wzero = (wm == '0);
    side_next.dzero = (d_c == '0);
    side_next.smp.x = quat.x_part;
    side_next.smp.y = quat.y_part;
    side_next.smp.z = quat.z_part;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
    if (adv) begin
      d    <= d_c;
      side <= side_next;
    end
  end

endmodule

// File: rtl/qeae_isqrt.sv
// Pipelined integer square root, one root bit per stage.
module qeae_isqrt #(
  parameter int RAD_W = 61,
  parameter int SB_W  = 1,
  localparam int ROOT_W = (RAD_W + 1) / 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  rad,
  input  logic [SB_W-1:0]   in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root,
  output logic [SB_W-1:0]   out_side
);

  localparam int CW = 2 * ROOT_W + 1;

  logic              vld [0:ROOT_W];
  logic [RAD_W-1:0]  rem [0:ROOT_W];
  logic [ROOT_W-1:0] q   [0:ROOT_W];
  logic [SB_W-1:0]   sb  [0:ROOT_W];

  assign vld[0] = in_valid;
  assign rem[0] = rad;
  assign q[0]   = '0;
  assign sb[0]  = in_side;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    localparam int B = ROOT_W - 1 - j;
    logic [CW-1:0] trial;
    logic          take;

    // (q + 2^B)^2 - q^2
    assign trial = (CW'(q[j]) << (B + 1)) + (CW'(1) << (2 * B));
    assign take  = CW'(rem[j]) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (adv) begin
        vld[j+1] <= vld[j];
      end
      if (adv) begin
        rem[j+1] <= take ? RAD_W'(CW'(rem[j]) - trial) : rem[j];
        q[j+1]   <= take ? (q[j] | (ROOT_W'(1) << B)) : q[j];
        sb[j+1]  <= sb[j];
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign root      = q[ROOT_W];
  assign out_side  = sb[ROOT_W];

endmodule

// File: rtl/qeae_div.sv
// Pipelined restoring divider, one quotient bit per stage, overflow flag.
module qeae_div #(
  parameter int NUM_W = 61,
  parameter int DEN_W = 31,
  parameter int Q_W   = 32,
  parameter int SB_W  = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [SB_W-1:0]  in_side,
  output logic             out_valid,
  output logic [Q_W-1:0]   quo,
  output logic             ovf,
  output logic [SB_W-1:0]  out_side
);

  localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic             vld [0:Q_W];
  logic [NUM_W-1:0] rem [0:Q_W];
  logic [DEN_W-1:0] dv  [0:Q_W];
  logic [Q_W-1:0]   q   [0:Q_W];
  logic             of  [0:Q_W];
  logic [SB_W-1:0]  sb  [0:Q_W];

  assign vld[0] = in_valid;
  assign rem[0] = num;
  assign dv[0]  = den;
  assign q[0]   = '0;
  // quotient does not fit in Q_W bits (also covers a zero divisor)
  assign of[0]  = CW'(num) >= (CW'(den) << Q_W);
  assign sb[0]  = in_side;

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    localparam int B = Q_W - 1 - j;
    logic [CW-1:0] trial;
    logic          take;

    assign trial = CW'(dv[j]) << B;
    assign take  = CW'(rem[j]) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (adv) begin
        vld[j+1] <= vld[j];
      end
      if (adv) begin
        rem[j+1] <= take ? NUM_W'(CW'(rem[j]) - trial) : rem[j];
        q[j+1]   <= take ? (q[j] | (Q_W'(1) << B)) : q[j];
        dv[j+1]  <= dv[j];
        of[j+1]  <= of[j];
        sb[j+1]  <= sb[j];
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign quo       = q[Q_W];
  assign ovf       = of[Q_W];
  assign out_side  = sb[Q_W];

endmodule

// File: rtl/qeae_cordic.sv
// Pipelined vectoring CORDIC for atan(k / |w|), one rotation per stage.
module qeae_cordic #(
  parameter int STEPS = 16,
  parameter int SB_W  = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [qeae_pkg::VAL_W-1:0]  w30,
  input  logic [qeae_pkg::QUO_W-1:0]  k,
  input  logic                        wzero,
  input  logic [SB_W-1:0]             in_side,
  output logic                        out_valid,
  output logic [qeae_pkg::VAL_W-1:0]  ang,
  output logic [SB_W-1:0]             out_side
);

  localparam int XW = qeae_pkg::XY_W;
  localparam int AW = qeae_pkg::ACC_W;

  logic                 vld [0:STEPS];
  logic signed [XW-1:0] cx  [0:STEPS];
  logic signed [XW-1:0] cy  [0:STEPS];
  logic signed [AW-1:0] az  [0:STEPS];
  logic                 wz  [0:STEPS];
  logic [SB_W-1:0]      sb  [0:STEPS];

  assign vld[0] = in_valid;
  assign cx[0]  = XW'(w30);
  assign cy[0]  = XW'(k);
  assign az[0]  = '0;
  assign wz[0]  = wzero;
  assign sb[0]  = in_side;

  for (genvar j = 0; j < STEPS; j++) begin : g_stage
    localparam logic signed [AW-1:0] STEP_ANG = AW'(qeae_pkg::ATAN_TABLE[j % 32]);
    logic signed [XW-1:0] cx_next;
    logic signed [XW-1:0] cy_next;
    logic signed [AW-1:0] az_next;

    always_comb begin
      if (!cy[j][XW-1]) begin
        cx_next = cx[j] + (cy[j] >>> (j % 32));
        cy_next = cy[j] - (cx[j] >>> (j % 32));
        az_next = az[j] + STEP_ANG;
      end else begin
        cx_next = cx[j] - (cy[j] >>> (j % 32));
        cy_next = cy[j] + (cx[j] >>> (j % 32));
        az_next = az[j] - STEP_ANG;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (adv) begin
        vld[j+1] <= vld[j];
      end
      if (adv) begin
        cx[j+1] <= cx_next;
        cy[j+1] <= cy_next;
        az[j+1] <= az_next;
        wz[j+1] <= wz[j];
        sb[j+1] <= sb[j];
      end
    end
  end

  // Clamp to [0, quarter turn]; zero w bypasses to exactly a quarter turn.
  logic [qeae_pkg::VAL_W-1:0] ang_next;

  always_comb begin
    if (wz[STEPS]) begin
      ang_next = qeae_pkg::ONE_Q30;
    end else if (az[STEPS][AW-1]) begin
      ang_next = '0;
    end else if (az[STEPS] > AW'(qeae_pkg::ONE_Q30)) begin
      ang_next = qeae_pkg::ONE_Q30;
    end else begin
      ang_next = az[STEPS][qeae_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[STEPS];
    end
    if (adv) begin
      ang      <= ang_next;
      out_side <= sb[STEPS];
    end
  end

  a_ang_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ang <= qeae_pkg::ONE_Q30)
    else $error("CORDIC angle beyond a quarter turn");

endmodule

// File: rtl/qeae_scale.sv
// Factor clamp and sign, three-lane multiply, rounding and saturation.
module qeae_scale (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [qeae_pkg::QUO_W-1:0]  quo,
  input  logic                        ovf,
  input  qeae_pkg::sd_side_t          side,
  output logic                        vec_valid,
  output qeae_pkg::vec_t              vec
);

  localparam int PW = qeae_pkg::PROD_W;
  localparam int TW = PW + 1;

  function automatic logic signed [qeae_pkg::SMP_W-1:0] round_sat(
    input logic signed [PW-1:0] p
  );
    logic signed [TW-1:0] t;
    t = (TW'(p) + (TW'(1) <<< 29)) >>> qeae_pkg::FRAC_W;
    if (t > TW'((1 <<< (qeae_pkg::SMP_W - 1)) - 1)) begin
      return qeae_pkg::SMP_W'((1 <<< (qeae_pkg::SMP_W - 1)) - 1);
    end else if (t < -TW'(1 <<< (qeae_pkg::SMP_W - 1))) begin
      return qeae_pkg::SMP_W'(1 <<< (qeae_pkg::SMP_W - 1));
    end else begin
      return t[qeae_pkg::SMP_W-1:0];
    end
  endfunction

  // stage 1: clamp and sign the factor
  logic [qeae_pkg::QUO_W-1:0]        s_c;
  logic signed [qeae_pkg::SF_W-1:0]  sf_next;
  logic                              v1;
  logic signed [qeae_pkg::SF_W-1:0]  sf;
  logic                              dz1;
  qeae_pkg::smp_t                    smp1;

  always_comb begin
    s_c = (ovf || quo > qeae_pkg::S_MAX) ? qeae_pkg::S_MAX : quo;
    sf_next = side.wneg ? -$signed({1'b0, s_c}) : $signed({1'b0, s_c});
  end

  // stage 2: products
  logic                      v2;
  logic                      dz2;
  logic signed [PW-1:0]      px;
  logic signed [PW-1:0]      py;
  logic signed [PW-1:0]      pz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      vec_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      vec_valid <= v2;
    end
    if (adv) begin
      sf   <= sf_next;
      dz1  <= side.dzero;
      smp1 <= side.smp;
      px   <= sf * smp1.x;
      py   <= sf * smp1.y;
      pz   <= sf * smp1.z;
      dz2  <= dz1;
      vec.vec_x <= dz2 ? '0 : round_sat(px);
      vec.vec_y <= dz2 ? '0 : round_sat(py);
      vec.vec_z <= dz2 ? '0 : round_sat(pz);
    end
  end

  a_sf_range: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (sf <= $signed({1'b0, qeae_pkg::S_MAX}) &&
            sf >= -$signed({1'b0, qeae_pkg::S_MAX})))
    else $error("scale factor beyond 2.0");

endmodule

// File: rtl/quaternion_equal_area_encode.sv
// Stages: 1 front, 31 root bits, 32 quotient bits for k, CORDIC_STEPS + 1 rotation,
// 32 quotient bits for the factor, 3 scale/multiply/round.
// Throughput: one transaction per cycle; the whole pipe holds while vec waits.
// Reset (rst, synchronous): all stage valid bits clear, guard_epsilon returns to 1.
module quaternion_equal_area_encode #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       quat_valid,
  output logic                       quat_ready,
  input  qeae_pkg::quat_t            quat,
  output logic                       vec_valid,
  input  logic                       vec_ready,
  output qeae_pkg::vec_t             vec,
  input  logic                       cfg_we,
  input  logic [qeae_pkg::EPS_W-1:0] cfg_wdata
);

  // Global advance: every stage moves when the output register is free or drains.
  logic adv;
  assign adv        = !vec_valid || vec_ready;
  assign quat_ready = adv;

  // Guard epsilon: user must write it only while the pipe is empty; not enforced.
  logic [qeae_pkg::EPS_W-1:0] guard_epsilon;

  always_ff @(posedge clk) begin
    if (rst) begin
      guard_epsilon <= qeae_pkg::EPS_RESET;
    end else if (cfg_we) begin
      guard_epsilon <= cfg_wdata;
    end
  end

  // Front: |w|, a, d and special-case flags.
  logic                        fr_valid;
  logic [qeae_pkg::VAL_W-1:0]  fr_d;
  qeae_pkg::sq_side_t          fr_side;

  qeae_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (quat_valid),
    .quat      (quat),
    .eps       (guard_epsilon),
    .out_valid (fr_valid),
    .d         (fr_d),
    .side      (fr_side)
  );

  // Root of d in Q2.30: floor(sqrt(d * 2^30)).
  logic                        sq_valid;
  logic [qeae_pkg::ROOT_W-1:0] sq_root;
  qeae_pkg::sq_side_t          sq_side;

  qeae_isqrt #(
    .RAD_W (qeae_pkg::RAD_W),
    .SB_W  ($bits(qeae_pkg::sq_side_t))
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (fr_valid),
    .rad       ({fr_d, qeae_pkg::FRAC_W'(0)}),
    .in_side   (fr_side),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  // k = a * 2^30 / root.
  qeae_pkg::kd_side_t          kd_in;
  qeae_pkg::kd_side_t          kd_side;
  logic                        kd_valid;
  logic [qeae_pkg::QUO_W-1:0]  kd_quo;
  logic                        kd_ovf;

  always_comb begin
    kd_in.root  = sq_root;
    kd_in.w30   = sq_side.w30;
    kd_in.wneg  = sq_side.wneg;
    kd_in.wzero = sq_side.wzero;
    kd_in.dzero = sq_side.dzero;
    kd_in.smp   = sq_side.smp;
  end

  qeae_div #(
    .NUM_W (qeae_pkg::RAD_W),
    .DEN_W (qeae_pkg::ROOT_W),
    .Q_W   (qeae_pkg::QUO_W),
    .SB_W  ($bits(qeae_pkg::kd_side_t))
  ) u_div_k (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sq_valid),
    .num       ({sq_side.a, qeae_pkg::FRAC_W'(0)}),
    .den       (sq_root),
    .in_side   (kd_in),
    .out_valid (kd_valid),
    .quo       (kd_quo),
    .ovf       (kd_ovf),
    .out_side  (kd_side)
  );

  // Angle of (|w|, k), scaled so a quarter turn is 2^30.
  qeae_pkg::co_side_t          co_in;
  qeae_pkg::co_side_t          co_side;
  logic                        co_valid;
  logic [qeae_pkg::VAL_W-1:0]  co_ang;
  logic [qeae_pkg::QUO_W-1:0]  k_val;

  always_comb begin
    // overflow only with a zero root, whose result is forced to zero later
    k_val       = kd_ovf ? '1 : kd_quo;
    co_in.root  = kd_side.root;
    co_in.wneg  = kd_side.wneg;
    co_in.dzero = kd_side.dzero;
    co_in.smp   = kd_side.smp;
  end

  qeae_cordic #(
    .STEPS (CORDIC_STEPS),
    .SB_W  ($bits(qeae_pkg::co_side_t))
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (kd_valid),
    .w30       (kd_side.w30),
    .k         (k_val),
    .wzero     (kd_side.wzero),
    .in_side   (co_in),
    .out_valid (co_valid),
    .ang       (co_ang),
    .out_side  (co_side)
  );

  // Factor s = angle * 2^30 / root.
  qeae_pkg::sd_side_t          sd_in;
  qeae_pkg::sd_side_t          sd_side;
  logic                        sd_valid;
  logic [qeae_pkg::QUO_W-1:0]  sd_quo;
  logic                        sd_ovf;

  always_comb begin
    sd_in.wneg  = co_side.wneg;
    sd_in.dzero = co_side.dzero;
    sd_in.smp   = co_side.smp;
  end

  qeae_div #(
    .NUM_W (qeae_pkg::RAD_W),
    .DEN_W (qeae_pkg::ROOT_W),
    .Q_W   (qeae_pkg::QUO_W),
    .SB_W  ($bits(qeae_pkg::sd_side_t))
  ) u_div_s (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (co_valid),
    .num       ({co_ang, qeae_pkg::FRAC_W'(0)}),
    .den       (co_side.root),
    .in_side   (sd_in),
    .out_valid (sd_valid),
    .quo       (sd_quo),
    .ovf       (sd_ovf),
    .out_side  (sd_side)
  );

  // Clamp, sign, multiply x/y/z, round half up and saturate into vec.
  qeae_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sd_valid),
    .quo       (sd_quo),
    .ovf       (sd_ovf),
    .side      (sd_side),
    .vec_valid (vec_valid),
    .vec       (vec)
  );

  // Reset must empty the output and restore the guard value.
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!vec_valid && guard_epsilon == qeae_pkg::EPS_RESET))
    else $error("reset did not clear output or guard epsilon");

  // An accepted transaction must land in the front stage.
  a_enter_front: assert property (@(posedge clk) disable iff (rst)
    (quat_valid && quat_ready) |=> fr_valid)
    else $error("accepted transaction lost at pipeline entry");

  // A stalled pipe holds its front stage.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(fr_valid) && $stable(fr_d)))
    else $error("front stage moved during a stall");

endmodule

// File: bench/quaternion_equal_area_encode_tb.sv
// Self-checking testbench for the quaternion equal-area encoder.
module quaternion_equal_area_encode_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Per-step rotation angles, a quarter turn being 2^30.
  localparam longint ROT_ANGLE [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861
  };
  localparam int PIPE_DEPTH = 116;

  // Expected-result store with the encoder predictor inside.
  class vec_scoreboard;
    qeae_pkg::vec_t pending[$];
    int             fails;
    longint         eps;

    function new();
      fails = 0;
      eps = 1;
    endfunction

    function longint floor_shift(longint v, int n);
      return v >>> n;
    endfunction

    function longint int_root(longint v);
      longint res, bitv;
      res = 0;
      bitv = 64'sd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function logic [15:0] scale_sample(longint sf, longint smp);
      longint p;
      p = floor_shift(sf * smp + (64'sd1 << 29), 30);
      if (p > 32767) p = 32767;
      if (p < -32768) p = -32768;
      return p[15:0];
    endfunction

    function qeae_pkg::vec_t encode(qeae_pkg::quat_t q);
      qeae_pkg::vec_t r;
      longint w, wm, w30, a, d, root, k, ang, cx, cy, nx, s;
      w = q.w_part;
      wm = (w < 0) ? -w : w;
      w30 = wm << 15;
      if (w30 > (64'sd1 << 30)) w30 = 64'sd1 << 30;
      a = (64'sd1 << 30) - ((w30 * w30) >> 30);
      d = a + eps;
      if (d == 0) return '0;
      root = int_root(d << 30);
      k = (a << 30) / root;
      if (w30 == 0) begin
        ang = 64'sd1 << 30;
      end else begin
        cx = w30;
        cy = k;
        ang = 0;
        for (int i = 0; i < 16; i++) begin
          if (cy >= 0) begin
            nx = cx + floor_shift(cy, i);
            cy = cy - floor_shift(cx, i);
            ang = ang + ROT_ANGLE[i];
          end else begin
            nx = cx - floor_shift(cy, i);
            cy = cy + floor_shift(cx, i);
            ang = ang - ROT_ANGLE[i];
          end
          cx = nx;
        end
        if (ang < 0) ang = 0;
        if (ang > (64'sd1 << 30)) ang = 64'sd1 << 30;
      end
      s = (ang << 30) / root;
      if (s > (64'sd1 << 31)) s = 64'sd1 << 31;
      if (w < 0) s = -s;
      r.vec_x = scale_sample(s, q.x_part);
      r.vec_y = scale_sample(s, q.y_part);
      r.vec_z = scale_sample(s, q.z_part);
      return r;
    endfunction

    function void note_quat(qeae_pkg::quat_t q);
      pending.push_back(encode(q));
    endfunction

    function void check_vec(qeae_pkg::vec_t v);
      qeae_pkg::vec_t e;
      if (pending.size() == 0) begin
        $error("unexpected vec transaction %h", v);
        fails++;
        return;
      end
      e = pending.pop_front();
      if (v.vec_x !== e.vec_x) begin
        $error("vec_x expected %0d got %0d", e.vec_x, v.vec_x);
        fails++;
      end
      if (v.vec_y !== e.vec_y) begin
        $error("vec_y expected %0d got %0d", e.vec_y, v.vec_y);
        fails++;
      end
      if (v.vec_z !== e.vec_z) begin
        $error("vec_z expected %0d got %0d", e.vec_z, v.vec_z);
        fails++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic quat_valid, quat_ready, vec_valid, vec_ready, cfg_we;
  qeae_pkg::quat_t quat;
  qeae_pkg::vec_t vec;
  logic [qeae_pkg::EPS_W-1:0] cfg_wdata;
  vec_scoreboard board;
  int hold_off;     // cycles of forced receiver stall still to run
  bit stall_mode;   // receiver pattern on or off

  quaternion_equal_area_encode u_top (
    .clk(clk), .rst(rst),
    .quat_valid(quat_valid), .quat_ready(quat_ready), .quat(quat),
    .vec_valid(vec_valid), .vec_ready(vec_ready), .vec(vec),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  // Score every accepted transaction on the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (quat_valid && quat_ready) board.note_quat(quat);
      if (vec_valid && vec_ready) board.check_vec(vec);
    end
  end

  // Receiver: honor a long hold-off first, otherwise stall on its own pattern in stall_mode, else stay ready.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      vec_ready <= 1'b0;
    end else if (stall_mode) begin
      vec_ready <= ($urandom_range(0, 3) != 0);
    end else begin
      vec_ready <= 1'b1;
    end
  end

  // Offer one transaction and hold it until accepted.
  task automatic send_quat(qeae_pkg::quat_t q);
    quat_valid <= 1'b1;
    quat <= q;
    @(posedge clk);
    while (!quat_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Lower valid for a gap whose length the caller gives.
  task automatic sender_gap(int n);
    quat_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic send_parts(int w, int x, int y, int z);
    qeae_pkg::quat_t q;
    q.w_part = w[15:0];
    q.x_part = x[15:0];
    q.y_part = y[15:0];
    q.z_part = z[15:0];
    send_quat(q);
  endtask

  // Drain the pipe, then write guard_epsilon while the block is idle.
  task automatic set_epsilon(int val);
    quat_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val[qeae_pkg::EPS_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    board.eps = val;
  endtask

  // A random quaternion, mostly with x, y and z shrunk by a random shift, else raw noise.
  function automatic qeae_pkg::quat_t random_quat();
    qeae_pkg::quat_t q;
    q = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0) begin
      q.x_part = $signed(q.x_part) >>> $urandom_range(1, 3);
      q.y_part = $signed(q.y_part) >>> $urandom_range(1, 3);
      q.z_part = $signed(q.z_part) >>> $urandom_range(1, 3);
    end
    return q;
  endfunction

  // Bursts of back-to-back transactions; valid drops only inside a gap.
  task automatic random_phase(int count);
    int left, burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 20);
      if ($urandom_range(0, 3) == 0) burst = 1;
      for (int i = 0; i < burst && left > 0; i++) begin
        send_quat(random_quat());
        left--;
      end
      if ($urandom_range(0, 2) != 0) sender_gap($urandom_range(1, 6));
    end
  endtask

  initial begin
    int eps_set [6];
    eps_set = '{0, 255, 1, 17, 128, 0};
    board = new();
    rst = 1'b1;
    quat_valid = 1'b0;
    quat = '0;
    vec_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    hold_off = 0;
    stall_mode = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, zero w, both signs of w, saturation.
    send_parts(0, 32767, -32768, 0);
    send_parts(0, 0, 0, 0);
    send_parts(32767, 1, -1, 100);
    send_parts(-32768, 32767, -32768, 32767);
    send_parts(-32767, 1000, -1000, 5);
    send_parts(1, 32767, 32767, -32768);
    send_parts(-1, 32767, -32768, 12345);
    send_parts(23170, 23170, 0, 0);
    send_parts(-23170, 0, -23170, 0);
    send_parts(16384, 16384, 16384, 16384);
    send_parts(-16384, -16384, -16384, -16384);
    send_parts(-1, -1, -1, -1);

    // Zero guard term: |w| = 1 exactly gives a zero root; near-one and zero w too.
    set_epsilon(0);
    send_parts(-32768, 32767, -32768, 777);
    send_parts(32767, 32767, -32768, 777);
    send_parts(0, 32767, -32768, 1);
    send_parts(-32768, -1, 1, 0);

    // Long receiver hold-off while the sender keeps offering past the pipe depth.
    hold_off = 300;
    stall_mode = 1'b1;
    random_phase(200);

    for (int p = 0; p < 6; p++) begin
      set_epsilon(eps_set[p]);
      stall_mode = (p % 2 == 0);
      random_phase(66);
    end

    quat_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 20) @(negedge clk);
    if (board.fails == 0 && board.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
